// ===== hdl/mbee_pkg.sv =====
package mbee_pkg;

  localparam int VERTEX_W = 16;
  localparam int FUNC_W   = 2;

  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
    logic [VERTEX_W-1:0] vertex_c;
  } in_word_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] edge_start;
    logic [VERTEX_W-1:0] edge_end;
    logic                edge_valid;
    logic                table_overflow;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_RD,
    ST_RD_CHK,
    ST_OUT
  } state_t;

endpackage

// ===== hdl/mbee_store.sv =====
module mbee_store
  import mbee_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int IW    = 16,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [IW-1:0] rd_start,
  output logic [IW-1:0] rd_end,
  output logic          rd_shared,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [IW-1:0] wr_start,
  input  logic [IW-1:0] wr_end,
  input  logic          wr_shared
);

  logic [2*IW:0] mem [DEPTH];
  logic [2*IW:0] q_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {wr_start, wr_end, wr_shared};
    if (rd_en) q_r <= mem[rd_addr];
  end

  assign rd_start  = q_r[2*IW:IW+1];
  assign rd_end    = q_r[IW:1];
  assign rd_shared = q_r[0];

endmodule

// ===== hdl/mesh_boundary_edge_extractor.sv =====
// Edge table in one synchronous memory, scanned linearly per edge.
// Add: each triangle edge scans entries 0..count-1 until a match, which is marked
//   shared; with no match the edge is appended, or dropped when the table is full.
// Read: skips shared entries from the cursor to the next unshared one, or returns
//   an exhausted word; clear resets count, cursor and overflow flag.
// One word in flight at a time. rst_n (sync, active low) clears count,
// cursor and overflow flag; memory contents are not cleared.
module mesh_boundary_edge_extractor
  import mbee_pkg::*;
#(
  parameter int INDEX_BITS    = 16,
  parameter int EDGE_CAPACITY = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int AW = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
  localparam int CW = AW + 1;
  localparam int IW = INDEX_BITS;

  state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, cur_r, cur_nxt, idx_r, idx_nxt;
  logic          ovf_r, ovf_nxt;
  logic [1:0]    ei_r, ei_nxt;
  logic [IW-1:0] va_r, vb_r, vc_r;
  out_word_t     obuf_r, obuf_nxt;
  logic          ov_r, ov_nxt;

  logic          rd_en, wr_en, m_sh, wr_sh;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [IW-1:0] m_s, m_e, wr_s, wr_e, ex, ey;

  mbee_store #(.DEPTH(EDGE_CAPACITY), .IW(IW), .AW(AW)) u_store (
    .clk, .rd_en, .rd_addr, .rd_start(m_s), .rd_end(m_e), .rd_shared(m_sh),
    .wr_en, .wr_addr, .wr_start(wr_s), .wr_end(wr_e), .wr_shared(wr_sh)
  );

  // current edge of the triangle
  always_comb begin
    case (ei_r)
      2'd0:    begin ex = va_r; ey = vb_r; end
      2'd1:    begin ex = vb_r; ey = vc_r; end
      default: begin ex = vc_r; ey = va_r; end
    endcase
  end

  logic hit;
  assign hit = (m_s == ex && m_e == ey) || (m_s == ey && m_e == ex);

  assign in_ready  = (st_r == ST_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = obuf_r;

  // sequencer
  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; cur_nxt = cur_r; idx_nxt = idx_r;
    ovf_nxt = ovf_r; ei_nxt = ei_r; obuf_nxt = obuf_r; ov_nxt = ov_r;
    rd_en = 1'b0; rd_addr = idx_r[AW-1:0];
    wr_en = 1'b0; wr_addr = idx_r[AW-1:0];
    wr_s = ex; wr_e = ey; wr_sh = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_data.func)
            FUNC_ADD: begin
              ei_nxt = 2'd0; idx_nxt = '0; st_nxt = ST_SCAN;
            end
            FUNC_READ: begin
              idx_nxt = cur_r; st_nxt = ST_RD;
            end
            FUNC_CLEAR: begin
              cnt_nxt = '0; cur_nxt = '0; ovf_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (idx_r < cnt_r) begin
          rd_en = 1'b1; st_nxt = ST_SCAN_CHK;
        end else begin
          // no match: append or drop
          if (cnt_r == CW'(EDGE_CAPACITY)) ovf_nxt = 1'b1;
          else begin
            wr_en = 1'b1; wr_addr = cnt_r[AW-1:0]; cnt_nxt = cnt_r + 1'b1;
          end
          if (ei_r == 2'd2) st_nxt = ST_IDLE;
          else begin ei_nxt = ei_r + 2'd1; idx_nxt = '0; end
        end
      end
      ST_SCAN_CHK: begin
        if (hit) begin
          wr_en = 1'b1; wr_s = m_s; wr_e = m_e; wr_sh = 1'b1;
          if (ei_r == 2'd2) st_nxt = ST_IDLE;
          else begin ei_nxt = ei_r + 2'd1; idx_nxt = '0; st_nxt = ST_SCAN; end
        end else begin
          idx_nxt = idx_r + 1'b1; st_nxt = ST_SCAN;
        end
      end
      ST_RD: begin
        if (idx_r < cnt_r) begin
          rd_en = 1'b1; st_nxt = ST_RD_CHK;
        end else begin
          obuf_nxt = '{edge_start: '0, edge_end: '0, edge_valid: 1'b0,
                       table_overflow: ovf_r};
          cur_nxt = cnt_r; st_nxt = ST_OUT;
        end
      end
      ST_RD_CHK: begin
        if (m_sh) begin
          idx_nxt = idx_r + 1'b1; st_nxt = ST_RD;
        end else begin
          obuf_nxt.edge_start = VERTEX_W'(m_s);
          obuf_nxt.edge_end   = VERTEX_W'(m_e);
          obuf_nxt.edge_valid = 1'b1;
          obuf_nxt.table_overflow = ovf_r;
          cur_nxt = idx_r + 1'b1; st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ov_r) begin ov_nxt = 1'b1; st_nxt = ST_IDLE; end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cnt_r <= '0; cur_r <= '0; ovf_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; cur_r <= cur_nxt; ovf_r <= ovf_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; ei_r <= ei_nxt; obuf_r <= obuf_nxt;
    if (in_valid && in_ready) begin
      va_r <= IW'(in_data.vertex_a);
      vb_r <= IW'(in_data.vertex_b);
      vc_r <= IW'(in_data.vertex_c);
    end
  end

  // checks
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(EDGE_CAPACITY)) else $error("entry count past capacity");
  a_cur_le: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= cnt_r) else $error("cursor beyond count");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !in_ready) else $error("accept while busy");
  a_exhaust: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.edge_valid) |-> (out_data.edge_start == '0))
    else $error("exhausted read with nonzero edge");

endmodule

// ===== tb/sv/mesh_boundary_edge_checker.sv =====
module mesh_boundary_edge_checker
  import mbee_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 1024;

  // shadow copy of the edge table
  logic [VERTEX_W-1:0] edge_from [CAPACITY];
  logic [VERTEX_W-1:0] edge_to [CAPACITY];
  logic                edge_shared [CAPACITY];
  int                  stored_edges;
  int                  scan_pos;
  logic                dropped_edge;

  out_word_t boundary_q[$];

  // append (x,y); a stored (x,y) or (y,x) is marked shared instead; drop if full
  function automatic void record_edge(logic [VERTEX_W-1:0] x, logic [VERTEX_W-1:0] y);
    for (int i = 0; i < stored_edges; i++) begin
      if ((edge_from[i] == x && edge_to[i] == y) || (edge_from[i] == y && edge_to[i] == x)) begin
        edge_shared[i] = 1'b1;
        return;
      end
    end
    if (stored_edges >= CAPACITY) begin
      dropped_edge = 1'b1;
      return;
    end
    edge_from[stored_edges]   = x;
    edge_to[stored_edges]     = y;
    edge_shared[stored_edges] = 1'b0;
    stored_edges++;
  endfunction

  // next unshared edge from the cursor, or an exhausted word
  function automatic out_word_t next_boundary();
    out_word_t w;
    int        i;
    i = scan_pos;
    while (i < stored_edges && edge_shared[i]) i++;
    w = '0;
    if (i < stored_edges) begin
      w.edge_start = edge_from[i];
      w.edge_end   = edge_to[i];
      w.edge_valid = 1'b1;
      scan_pos     = i + 1;
    end else begin
      scan_pos = stored_edges;
    end
    w.table_overflow = dropped_edge;
    return w;
  endfunction

  assign pending = boundary_q.size();

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      stored_edges <= 0;
      scan_pos     <= 0;
      dropped_edge <= 1'b0;
      fail_count   <= 0;
      boundary_q.delete();
    end else begin
      // input side
      if (in_valid && in_ready) begin
        case (in_data.func)
          FUNC_ADD: begin
            record_edge(in_data.vertex_a, in_data.vertex_b);
            record_edge(in_data.vertex_b, in_data.vertex_c);
            record_edge(in_data.vertex_c, in_data.vertex_a);
          end
          FUNC_READ: boundary_q.push_back(next_boundary());
          FUNC_CLEAR: begin
            stored_edges = 0;
            scan_pos     = 0;
            dropped_edge = 1'b0;
          end
          default: ;
        endcase
      end
      // result side
      if (out_valid && out_ready) begin
        if (boundary_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result word %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = boundary_q.pop_front();
          if (exp_w.edge_start !== out_data.edge_start || exp_w.edge_end !== out_data.edge_end
              || exp_w.edge_valid !== out_data.edge_valid
              || exp_w.table_overflow !== out_data.table_overflow) begin
            if (fail_count < 10)
              $display("mismatch: exp start %h end %h valid %b ovf %b, got %h %h %b %b",
                       exp_w.edge_start, exp_w.edge_end, exp_w.edge_valid,
                       exp_w.table_overflow, out_data.edge_start, out_data.edge_end,
                       out_data.edge_valid, out_data.table_overflow);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_mesh_boundary_edge_extractor.sv =====
module tb_mesh_boundary_edge_extractor;
  import mbee_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1576;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  int        fail_count;
  int        pending;
  logic      calm;
  logic      hold_go;

  mesh_boundary_edge_extractor dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  mesh_boundary_edge_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop
  initial begin
    #60_000_000;
    $display("Verification failed");
    $finish;
  end

  // offer one word, with a random gap first; valid stays up into the next call
  task automatic send_word(logic [FUNC_W-1:0] f, logic [VERTEX_W-1:0] a,
                           logic [VERTEX_W-1:0] b, logic [VERTEX_W-1:0] c);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_data.func     <= f;
    in_data.vertex_a <= a;
    in_data.vertex_b <= b;
    in_data.vertex_c <= c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic add_tri(int a, int b, int c);
    send_word(FUNC_ADD, a[15:0], b[15:0], c[15:0]);
  endtask

  // receiver: random stalls, one long hold-off, a calm window
  initial begin
    int cyc;
    int hold_left;
    bit held;
    out_ready = 1'b0;
    cyc = 0;
    hold_left = 0;
    held = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_go && !held) begin
        held = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (cyc > 30000 && cyc < 90000) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 31);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int pool;
    int base;
    int adds_since_clear;
    int pick;
    int wait_cnt;
    in_valid = 1'b0;
    in_data  = '0;
    calm     = 1'b0;
    hold_go  = 1'b0;
    rst_n    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: sharing, degenerate, extremes, unused code, reads
    add_tri(0, 1, 2);
    add_tri(2, 1, 3);
    add_tri(5, 5, 5);
    add_tri(16'hFFFF, 0, 16'hFFFF);
    add_tri(16'hAAAA, 16'h5555, 16'hFFFF);
    send_word(FUNC_UNUSED, 16'h1234, 16'h5678, 16'h9ABC);
    hold_go = 1'b1;
    repeat (9) send_word(FUNC_READ, '0, '0, '0);
    add_tri(7, 8, 9);
    send_word(FUNC_READ, '0, '0, '0);
    add_tri(8, 7, 10);
    send_word(FUNC_READ, '0, '0, '0);
    send_word(FUNC_READ, '0, '0, '0);
    send_word(FUNC_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(FUNC_READ, '0, '0, '0);

    // fill the table past capacity
    for (int i = 0; i < 345; i++) add_tri(3 * i, 3 * i + 1, 3 * i + 2);
    add_tri(1, 0, 5);
    repeat (4) send_word(FUNC_READ, '0, '0, '0);
    send_word(FUNC_CLEAR, '0, '0, '0);
    send_word(FUNC_READ, '0, '0, '0);

    // random: small meshes from a narrow vertex pool
    adds_since_clear = 0;
    pool = 6;
    base = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= 700 && n < 900);
      pick = $urandom_range(99);
      if (adds_since_clear > 25 || pick < 6) begin
        send_word(FUNC_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
        adds_since_clear = 0;
        pool = $urandom_range(12, 3);
        base = $urandom_range(16'hFFFF - pool);
      end else if (pick < 32) begin
        send_word(FUNC_READ, 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (pick < 35) begin
        send_word(FUNC_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (pick < 42) begin
        send_word(FUNC_ADD, 16'($urandom), 16'($urandom), 16'($urandom));
        adds_since_clear++;
      end else begin
        add_tri(base + $urandom_range(pool), base + $urandom_range(pool),
                base + $urandom_range(pool));
        adds_since_clear++;
      end
    end
    in_valid <= 1'b0;

    // drain
    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (500) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== mesh_boundary_edge_extractor.f =====
hdl/mbee_pkg.sv
hdl/mbee_store.sv
hdl/mesh_boundary_edge_extractor.sv
tb/sv/mesh_boundary_edge_checker.sv
tb/sv/tb_mesh_boundary_edge_extractor.sv
